/* rtl/mqsb_pkg.sv */
// ----------------------------------------------------------------------------
// mqsb_pkg
// Shared types and constants for the multi-queue shared buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package mqsb_pkg;

    localparam int SLOTS_DEF  = 16;
    localparam int QUEUES_DEF = 4;

    // stream payload widths, padded to whole bytes
    localparam int QN_W      = 3;
    localparam int VALUE_W   = 32;
    localparam int IN_DATA_W = 40;
    localparam int OUT_DATA_W = 40;

    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_POP  = 1'b1;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_DONE
    } t_state;

endpackage : mqsb_pkg

`default_nettype wire

/* rtl/mqsb_ram.sv */
// ----------------------------------------------------------------------------
// mqsb_ram
// Simple dual-port RAM: one write port, one read port, registered read data
// that holds while no read is issued.
// ----------------------------------------------------------------------------
`default_nettype none

module mqsb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule : mqsb_ram

`default_nettype wire

/* rtl/mqsb_seq.sv */
// ----------------------------------------------------------------------------
// mqsb_seq
// Operation sequencer: reads the queue table and slot store, works out the
// new pointers, writes them back and holds the result for the output side.
// ----------------------------------------------------------------------------
`default_nettype none

module mqsb_seq #(
    parameter int SLOTS  = 16,
    parameter int QUEUES = 4,
    localparam int LW  = $clog2(SLOTS + 1),
    localparam int AW  = $clog2(SLOTS),
    localparam int QAW = (QUEUES > 1) ? $clog2(QUEUES) : 1
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // operation in
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic                        i_mode,
    input  wire logic [mqsb_pkg::QN_W-1:0]    i_qn,
    input  wire logic [mqsb_pkg::VALUE_W-1:0] i_value,
    // result out
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output mqsb_pkg::t_status                o_status,
    output logic [mqsb_pkg::VALUE_W-1:0]     o_pop_value,
    // queue table: {tail, head}
    output logic                             o_q_re,
    output logic [QAW-1:0]                   o_q_raddr,
    input  wire logic [2*LW-1:0]             i_q_rdata,
    output logic                             o_q_we,
    output logic [QAW-1:0]                   o_q_waddr,
    output logic [2*LW-1:0]                  o_q_wdata,
    // slot store: {value, link}
    output logic                             o_s_re,
    output logic [AW-1:0]                    o_s_raddr,
    input  wire logic [mqsb_pkg::VALUE_W+LW-1:0] i_s_rdata,
    output logic                             o_s_we,
    output logic [AW-1:0]                    o_s_waddr,
    output logic [mqsb_pkg::VALUE_W+LW-1:0]  o_s_wdata
);

    import mqsb_pkg::*;

    localparam logic [LW-1:0] NIL = LW'(SLOTS);

    t_state                r_state, n_state;
    logic                  r_mode;
    logic [QAW-1:0]        r_qidx;
    logic                  r_qok;
    logic [VALUE_W-1:0]    r_value;
    logic [LW-1:0]         r_free_head, n_free_head;
    logic [LW-1:0]         r_fresh;
    logic [QUEUES-1:0]     r_qvalid;
    logic [LW-1:0]         r_head, r_tail, r_next_free;
    logic                  r_had_head;
    t_status               r_status, n_status;
    logic                  r_out_valid;
    t_status               r_out_status;
    logic [VALUE_W-1:0]    r_out_value;

    logic                  w_accept, w_commit, w_qv, w_act;
    logic [LW-1:0]         w_head, w_tail, w_slink, w_pop_next;
    logic [VALUE_W-1:0]    w_svalue, n_out_value;

    assign w_accept   = i_in_valid && o_in_ready;
    assign w_commit   = (r_state == S_DONE) && (!r_out_valid || i_out_ready);
    assign w_qv       = r_qok && r_qvalid[r_qidx];
    assign w_head     = w_qv ? i_q_rdata[LW-1:0] : NIL;
    assign w_tail     = i_q_rdata[2*LW-1:LW];
    assign w_slink    = i_s_rdata[LW-1:0];
    assign w_svalue   = i_s_rdata[VALUE_W+LW-1:LW];
    assign w_act      = (r_status == ST_DONE);
    // a single-entry queue has its head at the tail
    assign w_pop_next = (r_head == r_tail) ? NIL : w_slink;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) n_state = S_LOOK;
            end
            S_LOOK: n_state = S_DONE;
            S_DONE: begin
                if (w_commit) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // memory and handshake controls
    always_comb begin
        o_in_ready  = 1'b0;
        o_q_re      = 1'b0;
        o_q_raddr   = QAW'(32'(i_qn) - 32'd1);
        o_q_we      = 1'b0;
        o_q_waddr   = r_qidx;
        o_q_wdata   = '0;
        o_s_re      = 1'b0;
        o_s_raddr   = AW'(r_free_head);
        o_s_we      = 1'b0;
        o_s_waddr   = AW'(r_free_head);
        o_s_wdata   = {r_value, NIL};
        n_status    = r_status;
        n_free_head = r_free_head;
        n_out_value = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_q_re     = w_accept;
                o_s_re     = w_accept;
            end
            S_LOOK: begin
                if (r_mode == MODE_PUSH) begin
                    if (!r_qok || r_free_head == NIL) begin
                        n_status = ST_FULL;
                    end else begin
                        n_status = ST_DONE;
                        // new slot is free, so its value can go in early
                        o_s_we    = 1'b1;
                        o_s_re    = (w_head != NIL);
                        o_s_raddr = AW'(w_tail);
                    end
                end else begin
                    if (w_head == NIL) begin
                        n_status = ST_EMPTY;
                    end else begin
                        n_status  = ST_DONE;
                        o_s_re    = 1'b1;
                        o_s_raddr = AW'(w_head);
                    end
                end
            end
            S_DONE: begin
                if (r_mode == MODE_POP) begin
                    n_out_value = w_act ? w_svalue : '1;
                end
                if (w_commit && w_act) begin
                    o_q_we = 1'b1;
                    if (r_mode == MODE_PUSH) begin
                        o_s_we      = r_had_head;
                        o_s_waddr   = AW'(r_tail);
                        o_s_wdata   = {w_svalue, r_free_head};
                        o_q_wdata   = {r_free_head, r_had_head ? r_head : r_free_head};
                        n_free_head = r_next_free;
                    end else begin
                        o_s_we      = 1'b1;
                        o_s_waddr   = AW'(r_head);
                        o_s_wdata   = {w_svalue, r_free_head};
                        o_q_wdata   = {r_tail, w_pop_next};
                        n_free_head = r_head;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_free_head <= '0;
            r_fresh     <= '0;
            r_qvalid    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_free_head <= n_free_head;
            if (w_commit && w_act && r_mode == MODE_PUSH) begin
                r_qvalid[r_qidx] <= 1'b1;
                if (r_free_head == r_fresh) r_fresh <= r_fresh + LW'(1);
            end
            if (w_commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode  <= i_mode;
            r_qidx  <= QAW'(32'(i_qn) - 32'd1);
            r_qok   <= (i_qn != '0) && (32'(i_qn) <= 32'(QUEUES));
            r_value <= i_value;
        end
        if (r_state == S_LOOK) begin
            r_status   <= n_status;
            r_head     <= w_head;
            r_tail     <= w_tail;
            r_had_head <= (w_head != NIL);
            // never-used slots still chain to the next index
            r_next_free <= (r_free_head == r_fresh) ? r_free_head + LW'(1) : w_slink;
        end
        if (w_commit) begin
            r_out_status <= r_status;
            r_out_value  <= n_out_value;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_pop_value = r_out_value;

    // ------------------------------------------------------------------
    a_fresh_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fresh <= NIL)
        else $error("fresh slot count beyond store size");

    a_commit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_commit |=> (r_state == S_IDLE))
        else $error("sequencer did not return to idle after commit");

    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!o_s_we && !o_q_we))
        else $error("memory write while idle");

    a_pop_recycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_commit && w_act && r_mode == MODE_POP) |=> (r_free_head == $past(r_head)))
        else $error("popped slot not at front of free list");

endmodule : mqsb_seq

`default_nettype wire

/* rtl/multi_queue_shared_buffer_core.sv */
// ----------------------------------------------------------------------------
// multi_queue_shared_buffer_core
// Several FIFO queues held as linked lists in one shared slot store.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream carries one operation per transaction: a push of a value
//   onto a queue, or a pop from a queue (queues numbered from 1). The master
//   stream returns exactly one result per operation, in order: a status and
//   the popped value.
//   The result register is loaded in the write-back step: the queue table and
//   the free-list head are read at acceptance, the slot at the queue tail
//   (push) or head (pop) in the next cycle, in the look-up step, and links
//   and pointers are written back with the result in the write-back step.
//   The slot store has a single write port and registered reads. A new
//   operation is accepted only once the previous one has reached the result
//   register. The result register lets the next operation be taken while a
//   result waits; if the receiver stalls, the block holds in its write-back
//   step until the result register frees, then completes.
//   Reset (synchronous, active low) empties all queues and rebuilds the free
//   list at once; no clearing pass is needed, unused slots are tracked by a
//   fill count.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_queue_shared_buffer_core #(
    parameter int SLOTS  = mqsb_pkg::SLOTS_DEF,
    parameter int QUEUES = mqsb_pkg::QUEUES_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [0] mode, [3:1] queue_number, [35:4] push_value, [39:36] zero
    input  wire logic [mqsb_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // [1:0] status, [33:2] pop_value, [39:34] zero
    output logic [mqsb_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);

    import mqsb_pkg::*;

    localparam int LW  = $clog2(SLOTS + 1);
    localparam int AW  = $clog2(SLOTS);
    localparam int QAW = (QUEUES > 1) ? $clog2(QUEUES) : 1;
    localparam int SW  = VALUE_W + LW;

    logic                q_re, q_we, s_re, s_we;
    logic [QAW-1:0]      q_raddr, q_waddr;
    logic [2*LW-1:0]     q_rdata, q_wdata;
    logic [AW-1:0]       s_raddr, s_waddr;
    logic [SW-1:0]       s_rdata, s_wdata;
    t_status             status;
    logic [VALUE_W-1:0]  pop_value;

    mqsb_seq #(
        .SLOTS  (SLOTS),
        .QUEUES (QUEUES)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_mode      (s_axis_tdata[0]),
        .i_qn        (s_axis_tdata[QN_W:1]),
        .i_value     (s_axis_tdata[QN_W+VALUE_W:QN_W+1]),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_status    (status),
        .o_pop_value (pop_value),
        .o_q_re      (q_re),
        .o_q_raddr   (q_raddr),
        .i_q_rdata   (q_rdata),
        .o_q_we      (q_we),
        .o_q_waddr   (q_waddr),
        .o_q_wdata   (q_wdata),
        .o_s_re      (s_re),
        .o_s_raddr   (s_raddr),
        .i_s_rdata   (s_rdata),
        .o_s_we      (s_we),
        .o_s_waddr   (s_waddr),
        .o_s_wdata   (s_wdata)
    );

    // queue table: head and tail per queue
    mqsb_ram #(
        .WIDTH (2 * LW),
        .DEPTH (QUEUES)
    ) u_qtab (
        .i_clk   (i_clk),
        .i_we    (q_we),
        .i_waddr (q_waddr),
        .i_wdata (q_wdata),
        .i_re    (q_re),
        .i_raddr (q_raddr),
        .o_rdata (q_rdata)
    );

    // slot store: value and link per slot
    mqsb_ram #(
        .WIDTH (SW),
        .DEPTH (SLOTS)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_re    (s_re),
        .i_raddr (s_raddr),
        .o_rdata (s_rdata)
    );

    assign m_axis_tdata = {(OUT_DATA_W - VALUE_W - 2)'(0), pop_value, status};

endmodule : multi_queue_shared_buffer_core

`default_nettype wire
